// File: hw/rtl/ealu_pkg.sv
// Package for the 8-bit CPU ALU: operation codes, flag positions and beat types.
// Used by ealu_alu and by the eight_bit_cpu_alu_with_flags_core top level.
package ealu_pkg;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_ADC     = 5'd1,
    OP_SUB     = 5'd2,
    OP_SBC     = 5'd3,
    OP_AND     = 5'd4,
    OP_XOR     = 5'd5,
    OP_OR      = 5'd6,
    OP_CP      = 5'd7,
    OP_INC8    = 5'd8,
    OP_DEC8    = 5'd9,
    OP_RLCA    = 5'd10,
    OP_RRCA    = 5'd11,
    OP_RLA     = 5'd12,
    OP_RRA     = 5'd13,
    OP_CPL     = 5'd14,
    OP_DAA     = 5'd15,
    OP_ADD16   = 5'd16,
    OP_ADDSPE8 = 5'd17,
    OP_INC16   = 5'd18,
    OP_DEC16   = 5'd19
  } op_t;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_HIGH_LIM = 8'h99;
  localparam logic [3:0] DAA_LOW_LIM  = 4'h9;

  typedef struct packed {
    logic [4:0]  operation;
    logic [7:0]  accumulator;
    logic [7:0]  operand;
    logic [3:0]  flags_in;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } out_t;

endpackage

// File: hw/rtl/ealu_alu.sv
// Combinational datapath of the 8-bit CPU ALU: 8-bit and 16-bit operations and flags.
// Depends on ealu_pkg for operation codes, flag positions and beat types.
module ealu_alu
  import ealu_pkg::*;
(
  input  in_t  op,
  output out_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cin;
  logic        t_add;
  logic        t_sub;
  logic [8:0]  add_s;
  logic [4:0]  add_h;
  logic [8:0]  sub_d;
  logic [4:0]  sub_h;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [16:0] w_sum;
  logic [12:0] w_h;
  logic [15:0] sp_r;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;

  assign a   = op.accumulator;
  assign b   = op.operand;
  assign f   = op.flags_in;
  assign cin = f[FLAG_C];

  assign t_add = (op.operation == OP_ADC) ? cin : 1'b0;
  assign t_sub = (op.operation == OP_SBC) ? cin : 1'b0;

  assign add_s = {1'b0, a} + {1'b0, b} + {8'h00, t_add};
  assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t_add};
  assign sub_d = {1'b0, a} - {1'b0, b} - {8'h00, t_sub};
  assign sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t_sub};

  assign inc_r = b + 8'd1;
  assign dec_r = b - 8'd1;

  always_comb begin
    daa_adj = 8'h00;
    daa_c   = f[FLAG_C];
    if (f[FLAG_N]) begin
      if (f[FLAG_H]) daa_adj = daa_adj + DAA_LOW_ADJ;
      if (f[FLAG_C]) daa_adj = daa_adj + DAA_HIGH_ADJ;
      daa_r = a - daa_adj;
    end else begin
      if (f[FLAG_H] || (a[3:0] > DAA_LOW_LIM)) daa_adj = daa_adj + DAA_LOW_ADJ;
      if (f[FLAG_C] || (a > DAA_HIGH_LIM)) begin
        daa_adj = daa_adj + DAA_HIGH_ADJ;
        daa_c   = 1'b1;
      end
      daa_r = a + daa_adj;
    end
  end

  assign w_sum = {1'b0, op.word_a} + {1'b0, op.word_b};
  assign w_h   = {1'b0, op.word_a[11:0]} + {1'b0, op.word_b[11:0]};
  assign sp_r  = op.word_a + {{8{b[7]}}, b};
  assign sp_h  = {1'b0, op.word_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c  = {1'b0, op.word_a[7:0]} + {1'b0, b};

  always_comb begin
    res.result    = 16'h0000;
    res.flags_out = f;
    case (op.operation)
      OP_ADD, OP_ADC: begin
        res.result    = {8'h00, add_s[7:0]};
        res.flags_out = {add_s[7:0] == 8'h00, 1'b0, add_h[4], add_s[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res.result    = (op.operation == OP_CP) ? {8'h00, a} : {8'h00, sub_d[7:0]};
        res.flags_out = {sub_d[7:0] == 8'h00, 1'b1, sub_h[4], sub_d[8]};
      end
      OP_AND: begin
        res.result    = {8'h00, a & b};
        res.flags_out = {(a & b) == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res.result    = {8'h00, a ^ b};
        res.flags_out = {(a ^ b) == 8'h00, 3'b000};
      end
      OP_OR: begin
        res.result    = {8'h00, a | b};
        res.flags_out = {(a | b) == 8'h00, 3'b000};
      end
      OP_INC8: begin
        res.result    = {8'h00, inc_r};
        res.flags_out = {inc_r == 8'h00, 1'b0, b[3:0] == 4'hF, f[FLAG_C]};
      end
      OP_DEC8: begin
        res.result    = {8'h00, dec_r};
        res.flags_out = {dec_r == 8'h00, 1'b1, b[3:0] == 4'h0, f[FLAG_C]};
      end
      OP_RLCA: begin
        res.result    = {8'h00, a[6:0], a[7]};
        res.flags_out = {3'b000, a[7]};
      end
      OP_RRCA: begin
        res.result    = {8'h00, a[0], a[7:1]};
        res.flags_out = {3'b000, a[0]};
      end
      OP_RLA: begin
        res.result    = {8'h00, a[6:0], cin};
        res.flags_out = {3'b000, a[7]};
      end
      OP_RRA: begin
        res.result    = {8'h00, cin, a[7:1]};
        res.flags_out = {3'b000, a[0]};
      end
      OP_CPL: begin
        res.result    = {8'h00, ~a};
        res.flags_out = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
      end
      OP_DAA: begin
        res.result    = {8'h00, daa_r};
        res.flags_out = {daa_r == 8'h00, f[FLAG_N], 1'b0, daa_c};
      end
      OP_ADD16: begin
        res.result    = w_sum[15:0];
        res.flags_out = {f[FLAG_Z], 1'b0, w_h[12], w_sum[16]};
      end
      OP_ADDSPE8: begin
        res.result    = sp_r;
        res.flags_out = {2'b00, sp_h[4], sp_c[8]};
      end
      OP_INC16: begin
        res.result = op.word_a + 16'd1;
      end
      OP_DEC16: begin
        res.result = op.word_a - 16'd1;
      end
      default: begin
        res.result    = 16'h0000;
        res.flags_out = f;
      end
    endcase
  end

endmodule

// File: hw/rtl/eight_bit_cpu_alu_with_flags_core.sv
// 8-bit CPU ALU with Z/N/H/C flags: input register, ALU datapath, result register.
// A beat is held in the input register, passes the ALU datapath and is registered onto res.
// Throughput: one beat per cycle while res_stall is low; the single-pass datapath sets the rate.
// Reset (rst, synchronous, active high) empties both register stages.
// Depends on ealu_pkg and ealu_alu.
module eight_bit_cpu_alu_with_flags_core
  import ealu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_stall,
  input  in_t  op,
  output logic res_valid,
  input  logic res_stall,
  output out_t res
);

  logic s1_valid;
  in_t  s1_data;
  out_t alu_out;
  logic res_hold;
  logic s1_move;
  logic op_take;

  assign res_hold = res_valid && res_stall;
  assign s1_move  = s1_valid && !res_hold;
  assign op_stall = s1_valid && res_hold;
  assign op_take  = op_valid && !op_stall;

  ealu_alu u_alu (
    .op  (s1_data),
    .res (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!op_stall) s1_valid <= op_valid;
      if (!res_hold) res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) s1_data <= op;
    if (s1_move) res <= alu_out;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> (s1_valid && res_valid))
    else $error("input stalled while a stage is free");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> res_valid)
    else $error("advanced beat lost at the result register");

  a_cp_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    (s1_move && (s1_data.operation == OP_CP))
      |=> (res.result == {8'h00, $past(s1_data.accumulator)}))
    else $error("compare changed the accumulator");

endmodule
